FILE: hdl/crng_pkg.sv
// shared constants, types and state encoding for the combined lcg shuffle generator
package crng_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 8);
  localparam int Q_W        = $clog2(TABLE_SIZE + 1);

  localparam int VAL_W   = 31;
  localparam int MUL_W   = 16;
  localparam int PROD_W  = VAL_W + MUL_W;
  localparam int FOLD_W  = 8;
  localparam int SUM_W   = 32;
  localparam int RECIP_W = 16;
  localparam int RECIP_SHIFT = 40;

  localparam logic [VAL_W-1:0]  MOD1   = 31'd2147483563;
  localparam logic [VAL_W-1:0]  MOD2   = 31'd2147483399;
  localparam logic [VAL_W-1:0]  MOD1M1 = 31'd2147483562;
  localparam logic [MUL_W-1:0]  MUL1   = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL2   = 16'd40692;
  // 2^31 mod m for each modulus
  localparam logic [FOLD_W-1:0] FOLD1  = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD2  = 8'd249;

  localparam longint SLOT_DIV_L = 64'sd1 + (64'sd2147483562 / TABLE_SIZE);
  localparam logic [SUM_W-1:0]   SLOT_DIV   = SUM_W'(SLOT_DIV_L);
  localparam logic [RECIP_W-1:0] SLOT_RECIP =
    RECIP_W'((longint'(1) << RECIP_SHIFT) / SLOT_DIV_L);

  localparam logic [CNT_W-1:0] SEED_STEPS_M1 = CNT_W'(TABLE_SIZE + 7);

  typedef enum logic {
    GEN_FIRST,
    GEN_SECOND
  } gen_t;

  typedef struct packed {
    logic start;
    gen_t gen;
  } mm_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_RUN,
    ST_SEED_WAIT,
    ST_DRAW_SLOT1,
    ST_DRAW_SLOT2,
    ST_DRAW_READ,
    ST_DRAW_DONE
  } state_t;

endpackage

FILE: hdl/crng_ram.sv
// shuffle table storage: one write port, one registered read port
module crng_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 31,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/crng_modmul.sv
// three stage constant modular multiply: a*z mod (2^31 - c) by folding the high part
module crng_modmul
  import crng_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  mm_req_t          req,
  input  logic [VAL_W-1:0] z,
  output logic [VAL_W-1:0] result,
  output logic             done
);

  logic              v1;
  logic              v2;
  gen_t              gen1;
  gen_t              gen2;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  fold;
  logic [MUL_W-1:0]  mul_sel;
  logic [FOLD_W-1:0] fold_sel;
  logic [VAL_W-1:0]  mod_sel;

  assign mul_sel  = (req.gen == GEN_FIRST) ? MUL1 : MUL2;
  assign fold_sel = (gen1 == GEN_FIRST) ? FOLD1 : FOLD2;
  assign mod_sel  = (gen2 == GEN_FIRST) ? MOD1 : MOD2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      if (req.start) begin
        done <= 1'b0;
      end else if (v2) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= PROD_W'(z) * PROD_W'(mul_sel);
      gen1 <= req.gen;
    end
    if (v1) begin
      fold <= SUM_W'(prod[PROD_W-1:VAL_W]) * SUM_W'(fold_sel) + SUM_W'(prod[VAL_W-1:0]);
      gen2 <= gen1;
    end
    if (v2) begin
      if (fold >= SUM_W'(mod_sel)) begin
        result <= VAL_W'(fold - SUM_W'(mod_sel));
      end else begin
        result <= fold[VAL_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/crng_slot.sv
// table slot from previous output: reciprocal multiply, then one-step correction
module crng_slot
  import crng_pkg::*;
(
  input  logic              clk,
  input  logic              start,
  input  logic [VAL_W-1:0]  x,
  output logic [ADDR_W-1:0] slot
);

  localparam int P_W = VAL_W + RECIP_W;

  logic [P_W-1:0]   prod;
  logic [VAL_W-1:0] x1;
  logic [VAL_W-1:0] x2;
  logic [Q_W-1:0]   q0;
  logic [Q_W-1:0]   q0_est;
  logic [SUM_W-1:0] bound;
  logic [Q_W-1:0]   qsel;

  assign q0_est = Q_W'(prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= P_W'(x) * P_W'(SLOT_RECIP);
      x1   <= x;
    end
    q0    <= q0_est;
    x2    <= x1;
    bound <= (SUM_W'(q0_est) + SUM_W'(1)) * SLOT_DIV;
  end

  always_comb begin
    if (SUM_W'(x2) >= bound) begin
      qsel = q0 + Q_W'(1);
    end else begin
      qsel = q0;
    end
    if (qsel >= Q_W'(TABLE_SIZE)) begin
      slot = ADDR_W'(TABLE_SIZE - 1);
    end else begin
      slot = ADDR_W'(qsel);
    end
  end

endmodule

FILE: hdl/combined_lcg_shuffle_rng.sv
// top level: combined lcg pair with a shuffle table, sequencer and output register
// draw: an accepted beat runs the slot, read and done states through the three stage
//   modular multiply pipeline and the table read; no new beat is taken until idle
// reseed: 40 serial first generator steps
// reset: synchronous; the block seeds itself with one while s_tready is low
// the result register lets the next beat in while a result waits
module combined_lcg_shuffle_rng
  import crng_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // seed_value
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // random_value, zero pad
);

  state_t state;
  state_t state_next;

  logic [VAL_W-1:0]  first;
  logic [VAL_W-1:0]  second;
  logic [VAL_W-1:0]  last;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] slot_reg;
  logic              out_valid;
  logic [VAL_W-1:0]  out_data;

  logic              accept;
  logic              seed_load;
  logic              seed_step;
  logic              draw_commit;
  logic [VAL_W-1:0]  seed_mag;
  logic [31:0]       seed_neg;

  mm_req_t           mm1_req;
  mm_req_t           mm2_req;
  logic [VAL_W-1:0]  mm1_result;
  logic [VAL_W-1:0]  mm2_result;
  logic              mm1_done;
  logic              mm2_done;

  logic              slot_start;
  logic [ADDR_W-1:0] slot;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [VAL_W-1:0]  ram_rdata;

  logic signed [31:0] diff;
  logic [VAL_W-1:0]   draw_val;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

  // zero becomes one, negatives their magnitude, most negative saturates
  assign seed_neg = ~s_tdata + 32'd1;
  always_comb begin
    if (s_tdata == 32'd0) begin
      seed_mag = VAL_W'(1);
    end else if (s_tdata[31]) begin
      if (s_tdata == 32'h8000_0000) begin
        seed_mag = {VAL_W{1'b1}};
      end else begin
        seed_mag = seed_neg[VAL_W-1:0];
      end
    end else begin
      seed_mag = s_tdata[VAL_W-1:0];
    end
  end

  assign diff = $signed({1'b0, ram_rdata}) - $signed({1'b0, mm2_result});
  always_comb begin
    if (diff < 32'sd1) begin
      draw_val = VAL_W'(diff + $signed({1'b0, MOD1M1}));
    end else begin
      draw_val = diff[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    seed_load   = 1'b0;
    seed_step   = 1'b0;
    draw_commit = 1'b0;
    slot_start  = 1'b0;
    ram_re      = 1'b0;
    mm1_req     = '{start: 1'b0, gen: GEN_FIRST};
    mm2_req     = '{start: 1'b0, gen: GEN_SECOND};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser) begin
            state_next = ST_DRAW_SLOT1;
          end else begin
            seed_load  = 1'b1;
            state_next = ST_SEED_RUN;
          end
        end
      end
      ST_SEED_RUN: begin
        mm1_req.start = 1'b1;
        state_next    = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        if (mm1_done) begin
          seed_step = 1'b1;
          if (cnt == '0) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SEED_RUN;
          end
        end
      end
      ST_DRAW_SLOT1: begin
        mm1_req.start = 1'b1;
        mm2_req.start = 1'b1;
        slot_start    = 1'b1;
        state_next    = ST_DRAW_SLOT2;
      end
      ST_DRAW_SLOT2: begin
        state_next = ST_DRAW_READ;
      end
      ST_DRAW_READ: begin
        ram_re     = 1'b1;
        state_next = ST_DRAW_DONE;
      end
      ST_DRAW_DONE: begin
        if (!out_valid || m_tready) begin
          draw_commit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_reg;
    ram_wdata = mm1_result;
    if (seed_step && (cnt < CNT_W'(TABLE_SIZE))) begin
      ram_we    = 1'b1;
      ram_waddr = cnt[ADDR_W-1:0];
    end else if (draw_commit) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first     <= VAL_W'(1);
      second    <= VAL_W'(1);
      cnt       <= SEED_STEPS_M1;
      out_valid <= 1'b0;
    end else begin
      if (seed_load) begin
        first  <= seed_mag;
        second <= seed_mag;
        cnt    <= SEED_STEPS_M1;
      end
      if (seed_step) begin
        first <= mm1_result;
        cnt   <= cnt - CNT_W'(1);
      end
      if (draw_commit) begin
        first  <= mm1_result;
        second <= mm2_result;
      end
      if (draw_commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seed_step && (cnt == '0)) begin
      last <= mm1_result;
    end
    if (draw_commit) begin
      last     <= draw_val;
      out_data <= draw_val;
    end
    if (ram_re) begin
      slot_reg <= slot;
    end
  end

  crng_modmul u_mm1 (
    .clk    (clk),
    .rst    (rst),
    .req    (mm1_req),
    .z      (first),
    .result (mm1_result),
    .done   (mm1_done)
  );

  crng_modmul u_mm2 (
    .clk    (clk),
    .rst    (rst),
    .req    (mm2_req),
    .z      (second),
    .result (mm2_result),
    .done   (mm2_done)
  );

  crng_slot u_slot (
    .clk   (clk),
    .start (slot_start),
    .x     (last),
    .slot  (slot)
  );

  crng_ram #(
    .DEPTH  (TABLE_SIZE),
    .WIDTH  (VAL_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_draw_units_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_DONE) |-> (mm1_done && mm2_done))
    else $error("draw result taken before the multiply units finished");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    (draw_commit) |=> (m_tdata[30:0] != 31'd0 && m_tdata[30:0] <= MOD1M1))
    else $error("result outside 1..m1-1");

  a_seed_end: assert property (@(posedge clk) disable iff (rst)
    (seed_step && cnt == '0) |=> (state == ST_IDLE))
    else $error("reseed did not finish after the last step");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(seed_step && draw_commit))
    else $error("reseed and draw wrote the table together");
`endif

endmodule
